[hw/rtl/fxlg_pkg.sv]
package fxlg_pkg;

	// Field widths
	localparam int WORD_W  = 31;
	localparam int BOUND_W = 16;
	localparam int LAG_W   = 14;

	// Congruential fill: v' = 16807 * v mod (2^31 - 1)
	localparam int MULT_W = 15;
	localparam int PROD_W = WORD_W + MULT_W;
	localparam logic [MULT_W-1:0] LCG_MULT  = MULT_W'(16807);
	localparam logic [WORD_W-1:0] LCG_PRIME = WORD_W'(32'h7FFF_FFFF);

	// Lags behind the draw index
	localparam int NUM_TAPS = 4;
	localparam logic [LAG_W-1:0] LAGS [NUM_TAPS] = '{
		LAG_W'(471), LAG_W'(1586), LAG_W'(6988), LAG_W'(9689)
	};

	// Remainder unit: MOD_DIGIT quotient bits per cycle over a padded word
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = (WORD_W + MOD_DIGIT - 1) / MOD_DIGIT;
	localparam int MOD_PAD_W = MOD_DIGIT * MOD_STEPS;

	typedef enum logic {
		CMD_DRAW = 1'b0,
		CMD_SEED = 1'b1
	} cmd_t;

endpackage

[hw/rtl/fxlg_ram.sv]
module fxlg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/fxlg_mod.sv]
module fxlg_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fxlg_pkg::WORD_W-1:0]   dividend,
	input  logic [fxlg_pkg::BOUND_W-1:0]  divisor,
	output logic                          done,
	output logic [fxlg_pkg::BOUND_W-1:0]  remainder
);

	import fxlg_pkg::*;

	localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MOD_STEPS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_PAD_W-1:0] dvd_q;
	logic [BOUND_W:0]     rem_q;
	logic [BOUND_W-1:0]   div_q;
	logic [BOUND_W:0]     rem_c;
	logic [MOD_PAD_W-1:0] dvd_c;

	// Restoring remainder, MOD_DIGIT bits per cycle
	always_comb begin
		rem_c = rem_q;
		dvd_c = dvd_q;
		for (int i = 0; i < MOD_DIGIT; i++) begin
			rem_c = {rem_c[BOUND_W-1:0], dvd_c[MOD_PAD_W-1]};
			dvd_c = {dvd_c[MOD_PAD_W-2:0], 1'b0};
			if (rem_c >= {1'b0, div_q}) begin
				rem_c = rem_c - {1'b0, div_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= MOD_PAD_W'(dividend);
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				dvd_q <= dvd_c;
				rem_q <= rem_c;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	// zero bound gives zero
	assign remainder = (div_q == '0) ? '0 : rem_q[BOUND_W-1:0];

endmodule

[hw/rtl/four_tap_xor_lagged_random_generator.sv]
// Four-tap XOR lagged random generator (lags 471, 1586, 6988, 9689) over a
// history of HISTORY_DEPTH words of 31 bits held in one simple dual-port RAM.
// Each input word carries a command. A seed word fills the whole history with
// the chain v' = 16807 * v mod (2^31 - 1), starting from the seed, and returns
// a zero result; it leaves the draw index alone. A draw word advances the draw
// index, writes the XOR of the four lagged history words at the new index, and
// returns that word both raw (also readable as a Q0.31 fraction) and reduced
// modulo the given bound (zero for a bound of zero). Every input word gives
// exactly one output word. The block works on one word at a time: a draw
// runs four reads through the single RAM read port, one XOR-and-write step,
// a wait on the four-bit-per-cycle remainder unit, which is eight steps plus
// its done flag, a hand-off state that waits until the output register is
// free, and the idle state that takes the next word; a seed runs one chain
// step per history word, each a multiply state followed by a Mersenne
// fold-and-write state. The history needs no clearing pass after reset:
// until the first seed completes, RAM reads are treated as zero, which
// matches the all-zero history. The output register lets the next input
// word be taken while a finished result still waits downstream.
module four_tap_xor_lagged_random_generator #(
	parameter int HISTORY_DEPTH = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [fxlg_pkg::WORD_W-1:0]   seed_value,
	input  logic [fxlg_pkg::BOUND_W-1:0]  modulus,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fxlg_pkg::WORD_W-1:0]   raw_value,
	output logic [fxlg_pkg::BOUND_W-1:0]  bounded_value
);

	import fxlg_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(HISTORY_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam int TAP_W = $clog2(NUM_TAPS);
	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_WR,
		ST_DRAW_RD,
		ST_DRAW_XOR,
		ST_DRAW_MOD,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic                 seeded_q;    // history has been filled at least once
	logic                 is_seed_q;
	logic [IDX_W-1:0]     draw_idx_q;
	logic [IDX_W-1:0]     fill_idx_q;
	logic [WORD_W-1:0]    chain_q;
	logic [PROD_W-1:0]    prod_s1;
	logic [WORD_W-1:0]    acc_q;
	logic [TAP_W-1:0]     tap_q;
	logic [WORD_W-1:0]    word_q;
	logic [BOUND_W-1:0]   modulus_q;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    raw_q;
	logic [BOUND_W-1:0]   bounded_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	logic [WORD_W-1:0]    ram_rdata;
	logic [WORD_W-1:0]    rd_word;
	logic [WORD_W-1:0]    xor_c;
	logic [WORD_W:0]      fold_sum;
	logic [WORD_W-1:0]    fold_c;
	logic [IDX_W:0]       lag_x;
	logic [IDX_W:0]       idx_x;
	logic [IDX_W-1:0]     next_idx;
	logic                 mod_start;
	logic                 mod_done;
	logic [BOUND_W-1:0]   mod_rem;
	logic                 accept;
	logic                 out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Advance with wrap at the history depth
	assign next_idx = (draw_idx_q == LAST_IDX) ? '0 : draw_idx_q + 1'b1;

	// Lagged read address: index minus lag, wrapping around the depth
	assign lag_x = (IDX_W + 1)'(LAGS[tap_q]);
	assign idx_x = {1'b0, draw_idx_q};
	always_comb begin
		if (idx_x >= lag_x) begin
			ram_raddr = IDX_W'(idx_x - lag_x);
		end else begin
			ram_raddr = IDX_W'(idx_x + DEPTH_X - lag_x);
		end
	end

	// Before the first seed the whole history reads as zero
	assign rd_word = seeded_q ? ram_rdata : '0;
	assign xor_c   = acc_q ^ rd_word;

	// Mersenne fold: hi + lo, then one conditional subtract of the prime
	assign fold_sum = (WORD_W + 1)'(prod_s1[WORD_W-1:0])
	                + (WORD_W + 1)'(prod_s1[PROD_W-1:WORD_W]);
	assign fold_c   = (fold_sum >= {1'b0, LCG_PRIME})
	                ? WORD_W'(fold_sum - {1'b0, LCG_PRIME})
	                : fold_sum[WORD_W-1:0];

	assign ram_we    = (state_q == ST_SEED_WR) || (state_q == ST_DRAW_XOR);
	assign ram_waddr = (state_q == ST_SEED_WR) ? fill_idx_q : draw_idx_q;
	assign ram_wdata = (state_q == ST_SEED_WR) ? fold_c : xor_c;

	assign mod_start = (state_q == ST_DRAW_XOR);

	fxlg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fxlg_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (xor_c),
		.divisor  (modulus_q),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			is_seed_q   <= 1'b0;
			draw_idx_q  <= '0;
			fill_idx_q  <= '0;
			chain_q     <= '0;
			prod_s1     <= '0;
			acc_q       <= '0;
			tap_q       <= '0;
			word_q      <= '0;
			modulus_q   <= '0;
			out_valid_q <= 1'b0;
			raw_q       <= '0;
			bounded_q   <= '0;
		end else begin
			// drop the output word once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						modulus_q  <= modulus;
						acc_q      <= '0;
						tap_q      <= '0;
						fill_idx_q <= '0;
						chain_q    <= seed_value;
						if (cmd == CMD_SEED) begin
							is_seed_q <= 1'b1;
							state_q   <= ST_SEED_MUL;
						end else begin
							is_seed_q  <= 1'b0;
							draw_idx_q <= next_idx;
							state_q    <= ST_DRAW_RD;
						end
					end
				end
				ST_SEED_MUL: begin
					prod_s1 <= PROD_W'(chain_q) * PROD_W'(LCG_MULT);
					state_q <= ST_SEED_WR;
				end
				ST_SEED_WR: begin
					chain_q <= fold_c;
					if (fill_idx_q == LAST_IDX) begin
						seeded_q <= 1'b1;
						state_q  <= ST_DONE;
					end else begin
						fill_idx_q <= fill_idx_q + 1'b1;
						state_q    <= ST_SEED_MUL;
					end
				end
				ST_DRAW_RD: begin
					// data of the previous tap arrives while the next is issued
					if (tap_q != '0) begin
						acc_q <= xor_c;
					end
					tap_q <= tap_q + 1'b1;
					if (tap_q == LAST_TAP) begin
						state_q <= ST_DRAW_XOR;
					end
				end
				ST_DRAW_XOR: begin
					word_q  <= xor_c;
					state_q <= ST_DRAW_MOD;
				end
				ST_DRAW_MOD: begin
					if (mod_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						raw_q       <= is_seed_q ? '0 : word_q;
						bounded_q   <= is_seed_q ? '0 : mod_rem;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign raw_value     = raw_q;
	assign bounded_value = bounded_q;

endmodule
